// ----- rtl/kst_pkg.sv -----
package kst_pkg;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   // occupied_count saturates here
   localparam int COUNT_MAX = 31;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 2'd0,
      KIND_FIND    = 2'd1,
      KIND_REMOVE  = 2'd2,
      KIND_REPLACE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_MATCH = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // write one zero entry of the clearing pass
      logic start;       // capture the request and rewind the scan
      logic scan;        // issue the next slot read
      logic settle;      // scan ended: write back and record the result
      logic load_rsp;    // move the result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last slot
      logic hit;         // slot under test qualifies
      logic miss;        // last slot tested without a hit
      logic out_free;    // output register can take a result
   } sts_type;

endpackage

// ----- rtl/kst_if.sv -----
interface kst_req_if;
   logic                         valid;
   logic                         ready;
   logic [kst_pkg::KIND_W-1:0]   kind;
   logic [kst_pkg::KEY_W-1:0]    key;
   logic [kst_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface kst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kst_pkg::STATUS_W-1:0]  status;
   logic [kst_pkg::VALUE_W-1:0]   value_out;
   logic [kst_pkg::COUNT_W-1:0]   occupied_count;

   modport source (output valid, output status, output value_out, output occupied_count,
                   input ready);
   modport sink   (input valid, input status, input value_out, input occupied_count,
                   output ready);
endinterface

// ----- rtl/kst_ctrl.sv -----
module kst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kst_pkg::sts_type  sts,
   output kst_pkg::cmd_type  cmd
);

   kst_pkg::state_type state_ff;
   kst_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kst_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kst_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = kst_pkg::ST_IDLE;
         end
         kst_pkg::ST_IDLE: begin
            if (req_valid) state_in = kst_pkg::ST_SCAN;
         end
         kst_pkg::ST_SCAN: begin
            if (sts.hit || sts.miss) state_in = kst_pkg::ST_DONE;
         end
         kst_pkg::ST_DONE: begin
            if (sts.out_free) state_in = kst_pkg::ST_IDLE;
         end
         default: state_in = kst_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         kst_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         kst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         kst_pkg::ST_SCAN: begin
            cmd.scan   = 1'b1;
            cmd.settle = sts.hit || sts.miss;
         end
         kst_pkg::ST_DONE: begin
            cmd.load_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/kst_dp.sv -----
module kst_dp #(
   parameter int SLOTS       = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kst_pkg::cmd_type              cmd,
   output kst_pkg::sts_type              sts,
   input  logic [kst_pkg::KIND_W-1:0]    req_kind,
   input  logic [kst_pkg::KEY_W-1:0]     req_key,
   input  logic [kst_pkg::VALUE_W-1:0]   req_value,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [kst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kst_pkg::VALUE_W-1:0]   rsp_value_out,
   output logic [kst_pkg::COUNT_W-1:0]   rsp_occupied_count
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = kst_pkg::KEY_W + HANDLE_BITS;

   // slot store: key in the upper bits, handle in the lower bits
   logic [EW-1:0] mem [SLOTS];

   logic [CW-1:0]            scan_addr_ff, scan_addr_in;
   logic [EW-1:0]            rd_data_ff;
   logic [AW-1:0]            rd_idx_ff;
   logic                     rd_live_ff, rd_live_in;
   kst_pkg::kind_type        kind_ff;
   logic [kst_pkg::KEY_W-1:0] key_ff;
   logic [HANDLE_BITS-1:0]   val_ff;
   logic [CW-1:0]            count_ff, count_in;
   kst_pkg::status_type      res_status_ff, res_status_in;
   logic [kst_pkg::VALUE_W-1:0] res_found_ff, res_found_in;
   logic [kst_pkg::COUNT_W-1:0] res_count_ff, res_count_in;
   logic                     out_valid_ff, out_valid_in;
   logic [kst_pkg::STATUS_W-1:0] out_status_ff;
   logic [kst_pkg::VALUE_W-1:0]  out_found_ff;
   logic [kst_pkg::COUNT_W-1:0]  out_count_ff;

   logic [kst_pkg::KEY_W-1:0] rd_key;
   logic [HANDLE_BITS-1:0]    rd_hdl;
   logic                      rd_issue;
   logic                      match;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [EW-1:0]             wr_data;

   assign rd_key   = rd_data_ff[EW-1:HANDLE_BITS];
   assign rd_hdl   = rd_data_ff[HANDLE_BITS-1:0];
   assign rd_issue = cmd.scan && (scan_addr_ff < CW'(SLOTS));
   assign rd_live_in = rd_issue;

   // insert wants a free slot; the others want an occupied slot with the key
   always_comb begin
      if (kind_ff == kst_pkg::KIND_INSERT) begin
         match = rd_live_ff && (rd_hdl == '0);
      end else begin
         match = rd_live_ff && (rd_hdl != '0) && (rd_key == key_ff);
      end
   end

   assign sts.hit        = match;
   assign sts.miss       = rd_live_ff && !match && (rd_idx_ff == AW'(SLOTS - 1));
   assign sts.clear_last = (scan_addr_ff == CW'(SLOTS - 1));
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.start) begin
         scan_addr_in = '0;
      end else if ((cmd.scan || cmd.clear_step) && (scan_addr_ff < CW'(SLOTS))) begin
         scan_addr_in = scan_addr_ff + CW'(1);
      end
   end

   // clearing write, and write-back and result of the finishing scan step
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = '0;
      count_in      = count_ff;
      res_status_in = kst_pkg::STATUS_DONE;
      res_found_in  = '0;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = scan_addr_ff[AW-1:0];
      end else if (cmd.settle) begin
         if (!match) begin
            if (kind_ff == kst_pkg::KIND_INSERT) begin
               res_status_in = kst_pkg::STATUS_FULL;
            end else begin
               res_status_in = kst_pkg::STATUS_NO_MATCH;
            end
         end else begin
            case (kind_ff)
               kst_pkg::KIND_INSERT: begin
                  wr_en   = 1'b1;
                  wr_data = {key_ff, val_ff};
                  if (val_ff != '0) count_in = count_ff + CW'(1);
               end
               kst_pkg::KIND_FIND: begin
                  res_found_in = kst_pkg::VALUE_W'(rd_hdl);
               end
               kst_pkg::KIND_REMOVE: begin
                  wr_en    = 1'b1;
                  count_in = count_ff - CW'(1);
               end
               kst_pkg::KIND_REPLACE: begin
                  wr_en   = 1'b1;
                  wr_data = {rd_key, val_ff};
                  if (val_ff == '0) count_in = count_ff - CW'(1);
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
      end
      if (32'(count_in) > 32'(kst_pkg::COUNT_MAX)) begin
         res_count_in = kst_pkg::COUNT_W'(kst_pkg::COUNT_MAX);
      end else begin
         res_count_in = kst_pkg::COUNT_W'(count_in);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_rsp) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_issue) rd_data_ff <= mem[scan_addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_live_ff   <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         rd_live_ff   <= rd_live_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff[AW-1:0];
      if (cmd.start) begin
         kind_ff <= kst_pkg::kind_type'(req_kind);
         key_ff  <= req_key;
         val_ff  <= HANDLE_BITS'(req_value);
      end
      if (cmd.settle) begin
         res_status_ff <= res_status_in;
         res_found_ff  <= res_found_in;
         res_count_ff  <= res_count_in;
      end
      if (cmd.load_rsp) begin
         out_status_ff <= res_status_ff;
         out_found_ff  <= res_found_ff;
         out_count_ff  <= res_count_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_value_out      = out_found_ff;
   assign rsp_occupied_count = out_count_ff;

endmodule

// ----- rtl/keyed_slot_table.sv -----
// Channel  Dir  Payload                                    Transfer when
// req_ch   in   kind[1:0] key[63:0] value[31:0]            valid && ready
// rsp_ch   out  status[1:0] value_out[31:0] occupied[4:0]  valid && ready
//
// One request at a time. A request is decided at the first slot that qualifies (or the
// last slot when nothing qualifies), found by the linear scan that reads one slot per
// cycle from the store port. After reset a clearing pass writes every slot to free;
// req_ch.ready stays low until it ends. The result sits in an output register, so a
// new request is taken while rsp_ch is stalled; a finished scan holds until that
// register frees.
module keyed_slot_table #(
   parameter int SLOTS       = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   kst_req_if.sink      req_ch,
   kst_rsp_if.source    rsp_ch
);

   kst_pkg::cmd_type cmd;
   kst_pkg::sts_type sts;

   // sequencer: clearing pass, scan, write-back, result hand-off
   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot store, scan compare, occupancy count and output register
   kst_dp #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_kind           (req_ch.kind),
      .req_key            (req_ch.key),
      .req_value          (req_ch.value),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_status         (rsp_ch.status),
      .rsp_value_out      (rsp_ch.value_out),
      .rsp_occupied_count (rsp_ch.occupied_count)
   );

`ifndef SYNTH
   // drop ready for the whole scan once a request transfers
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while a scan is in progress");

   // a result appears only through a load command
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.load_rsp))
      else $error("response valid without a load");

   // never write back during the clearing pass
   a_no_settle_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && (cmd.settle || cmd.start)))
      else $error("scan activity during the clearing pass");

   // reported occupancy never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.occupied_count) <= SLOTS))
      else $error("occupied count above slot count");
`endif

endmodule

// ----- verif/slot_table_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the slot table and checks every
// reply against the oldest one owed.
module slot_table_checker #(
   parameter int SLOTS       = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   kst_req_if   req_ch,
   kst_rsp_if   rsp_ch,
   output int   mismatches,
   output int   replies_owed
);

   typedef struct {
      kst_pkg::status_type         status;
      logic [kst_pkg::VALUE_W-1:0] value_out;
      logic [kst_pkg::COUNT_W-1:0] occupied;
   } reply_type;

   localparam logic [kst_pkg::VALUE_W-1:0] HANDLE_MASK =
      kst_pkg::VALUE_W'({HANDLE_BITS{1'b1}});

   logic [kst_pkg::KEY_W-1:0]   slot_key    [SLOTS];
   logic [kst_pkg::VALUE_W-1:0] slot_handle [SLOTS];
   reply_type                   owed_q      [$];
   int                          fail_count = 0;

   // Free slots never match, so a stale key left behind cannot be found.
   function automatic int lowest_match(logic [kst_pkg::KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_handle[i] != '0 && slot_key[i] == key)
            return i;
      return SLOTS;
   endfunction

   function automatic reply_type apply_request(kst_pkg::kind_type kind,
                                               logic [kst_pkg::KEY_W-1:0] key,
                                               logic [kst_pkg::VALUE_W-1:0] handle);
      reply_type r;
      int        slot;
      int        used;
      r.status    = kst_pkg::STATUS_DONE;
      r.value_out = '0;
      handle      = handle & HANDLE_MASK;
      if (kind == kst_pkg::KIND_INSERT) begin
         slot = SLOTS;
         for (int i = SLOTS - 1; i >= 0; i--)
            if (slot_handle[i] == '0)
               slot = i;
         if (slot < SLOTS) begin
            slot_key[slot]    = key;
            slot_handle[slot] = handle;
         end else begin
            r.status = kst_pkg::STATUS_FULL;
         end
      end else begin
         slot = lowest_match(key);
         if (slot == SLOTS) begin
            r.status = kst_pkg::STATUS_NO_MATCH;
         end else begin
            case (kind)
               kst_pkg::KIND_FIND: begin
                  r.value_out = slot_handle[slot];
               end
               kst_pkg::KIND_REMOVE: begin
                  slot_key[slot]    = '0;
                  slot_handle[slot] = '0;
               end
               default: begin
                  slot_handle[slot] = handle;
               end
            endcase
         end
      end
      used = 0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_handle[i] != '0)
            used++;
      r.occupied = kst_pkg::COUNT_W'(used > kst_pkg::COUNT_MAX ? kst_pkg::COUNT_MAX : used);
      return r;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]    = '0;
            slot_handle[i] = '0;
         end
         owed_q.delete();
      end else begin
         // Retire first: a reply can never belong to a request taken at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_q.size() == 0) begin
               $error("reply with nothing owed: status %0h value_out %0h count %0h",
                      rsp_ch.status, rsp_ch.value_out, rsp_ch.occupied_count);
               fail_count++;
            end else begin
               want = owed_q.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_ch.status));
               compare_field("value_out", 64'(want.value_out), 64'(rsp_ch.value_out));
               compare_field("occupied_count", 64'(want.occupied),
                             64'(rsp_ch.occupied_count));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want   = apply_request(kst_pkg::kind_type'(req_ch.kind), req_ch.key,
                                   req_ch.value);
            owed_q = {owed_q, want};
         end
      end
      replies_owed <= owed_q.size();
      mismatches   <= fail_count;
   end

endmodule

// ----- verif/keyed_slot_table_test.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for keyed_slot_table. A directed opener walks the corner
// cases, then a long random run swings the table between filling and draining
// over a small pool of keys so that hits, shadowed duplicates and full inserts
// keep happening. All reply checking lives in slot_table_checker.
module keyed_slot_table_test;

   localparam int SLOTS         = 16;
   localparam int HANDLE_BITS   = 32;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int MAX_GAP       = 8;
   localparam int KEY_POOL      = 12;
   // long receiver hold-off, so the output register fills and the input stalls
   localparam int HOLD_AT_REPLY = 500;
   localparam int HOLD_CYCLES   = 150;
   // sender drains every outstanding reply before this random item
   localparam int PAUSE_AT_ITEM = 1000;
   // cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT   = 1000;
   localparam logic [kst_pkg::KEY_W-1:0] KEY_A = 64'h0123_4567_89AB_CDEF;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   replies_owed;
   int   quiet_cycles  = 0;
   int   replies_taken = 0;
   bit   sender_calm   = 1'b0;
   bit   receiver_calm = 1'b0;
   logic [kst_pkg::KEY_W-1:0] key_pool [KEY_POOL];

   kst_req_if req_ch ();
   kst_rsp_if rsp_ch ();

   keyed_slot_table #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   slot_table_checker #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) table_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .mismatches   (mismatches),
      .replies_owed (replies_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle for a random gap (none in calm stretches), then hold the request
   // until the transfer edge. Valid stays high into the next call when the
   // gap is zero, so back-to-back items go out without a bubble.
   task automatic offer(kst_pkg::kind_type kind, logic [kst_pkg::KEY_W-1:0] key,
                        logic [kst_pkg::VALUE_W-1:0] value);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.key   <= key;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every owed reply has come back. The extra edge
   // lets the owed count pick up the transfer that just happened.
   task automatic wait_replies_home();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   // Sender: reset, directed opener, random run, verdict.
   initial begin
      int                          kind_roll;
      int                          insert_share;
      int                          remove_share;
      bit                          filling;
      kst_pkg::kind_type           kind;
      logic [kst_pkg::KEY_W-1:0]   key;
      logic [kst_pkg::VALUE_W-1:0] value;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= kst_pkg::KIND_INSERT;
      req_ch.key   <= '0;
      req_ch.value <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++)
         key_pool[i] = {$urandom(), $urandom()};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Key 0 must not hit the cleared (free) slots.
      offer(kst_pkg::KIND_FIND, '0, '0);
      // Null-handle insert writes the key but the slot stays free.
      offer(kst_pkg::KIND_INSERT, KEY_A, '0);
      offer(kst_pkg::KIND_FIND, KEY_A, '0);
      // Extremes of key and handle.
      offer(kst_pkg::KIND_INSERT, '1, '1);
      offer(kst_pkg::KIND_INSERT, '0, 32'd1);
      offer(kst_pkg::KIND_FIND, '0, '0);
      // Duplicate key: the lower slot shadows the later one.
      offer(kst_pkg::KIND_INSERT, '0, 32'd2);
      offer(kst_pkg::KIND_FIND, '0, '0);
      // Null replace frees the lower slot, exposing the duplicate.
      offer(kst_pkg::KIND_REPLACE, '0, '0);
      offer(kst_pkg::KIND_FIND, '0, '0);
      offer(kst_pkg::KIND_REMOVE, '0, '0);
      // No match on remove and on replace.
      offer(kst_pkg::KIND_REMOVE, '0, '0);
      offer(kst_pkg::KIND_REPLACE, KEY_A, 32'h5555_AAAA);
      // One slot is taken: fill the other fifteen, then overflow once.
      for (int i = 0; i < SLOTS; i++)
         offer(kst_pkg::KIND_INSERT, {$urandom(), 32'(i)}, 32'(i) + 32'd1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
         if (n == PAUSE_AT_ITEM)
            wait_replies_home();
         // Alternate insert-heavy and remove-heavy stretches so the table
         // runs from empty to full and back.
         filling      = ((n / 150) % 2 == 0);
         insert_share = filling ? 50 : 15;
         remove_share = filling ? 10 : 45;
         kind_roll    = $urandom_range(0, 99);
         if (kind_roll < insert_share)
            kind = kst_pkg::KIND_INSERT;
         else if (kind_roll < insert_share + 25)
            kind = kst_pkg::KIND_FIND;
         else if (kind_roll < insert_share + 25 + remove_share)
            kind = kst_pkg::KIND_REMOVE;
         else
            kind = kst_pkg::KIND_REPLACE;
         // Mostly pooled keys so lookups hit; the rest are fresh noise.
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
         else
            key = {$urandom(), $urandom()};
         case ($urandom_range(0, 15))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom();
         endcase
         offer(kind, key, value);
      end

      wait_replies_home();
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatches == 0)
         $display("keyed_slot_table verification clean");
      else
         $display("keyed_slot_table verification failed");
      $finish;
   end

   // Receiver: random stall before each reply, calm stretches, and one long
   // hold-off while the sender keeps pushing.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (replies_taken % 50 == 0)
            receiver_calm = ($urandom_range(0, 3) == 0);
         stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         replies_taken++;
         if (replies_taken == HOLD_AT_REPLY) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   // Watchdog: any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("keyed_slot_table verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
rtl/kst_pkg.sv
rtl/kst_if.sv
rtl/kst_ctrl.sv
rtl/kst_dp.sv
rtl/keyed_slot_table.sv
verif/slot_table_checker.sv
verif/keyed_slot_table_test.sv
